### sv/hsvrgb_pkg.sv
// Shared types, sector codes and divider constants for the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

  // Widths of the exact-rational numerators and of the intermediate factors.
  localparam int NUM_W  = 28;
  localparam int VK_W   = 15;
  localparam int WT_W   = 13;
  localparam int SECT_W = 4;

  // Hue sectors of sixty degrees; the last case covers everything above four.
  localparam logic [SECT_W-1:0] SEC_RY = 4'd0;
  localparam logic [SECT_W-1:0] SEC_YG = 4'd1;
  localparam logic [SECT_W-1:0] SEC_GC = 4'd2;
  localparam logic [SECT_W-1:0] SEC_CB = 4'd3;
  localparam logic [SECT_W-1:0] SEC_BM = 4'd4;

  // Percent ceiling and the hue sector span.
  localparam logic [6:0] PCT_MAX   = 7'd100;
  localparam int         SECT_SPAN = 60;
  localparam int         SECT_MAXK = 8;

  // Division by 600000 is a shift by six followed by a division by 9375,
  // done as a multiply by a truncated reciprocal and one correction step.
  localparam int          DIV_SHIFT = 6;
  localparam int          DIV_X_W   = NUM_W - DIV_SHIFT;
  localparam int          DIV_ODD   = 9375;
  localparam int          RCP_W     = 19;
  localparam int          RCP_SHIFT = 32;
  localparam longint      DIV_RCP   = (64'd1 << RCP_SHIFT) / DIV_ODD;
  localparam int          Q_W       = 9;

  // Beat leaving the product stages.
  typedef struct packed {
    logic              valid;
    logic [SECT_W-1:0] sector;
    logic [NUM_W-1:0]  hi;
    logic [NUM_W-1:0]  lo;
    logic [NUM_W-1:0]  adj;
  } prod_beat_t;

  // Beat leaving the channel mix stage.
  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] red;
    logic [NUM_W-1:0] green;
    logic [NUM_W-1:0] blue;
  } chan_beat_t;

endpackage

`default_nettype wire

### sv/hsvrgb_prep.sv
// Front stages: clamping, sector split and the max, min and adjust numerators.
`default_nettype none

module hsvrgb_prep (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      fire,
  input  wire  [8:0]               hue,
  input  wire  [6:0]               saturation,
  input  wire  [6:0]               brightness,
  output hsvrgb_pkg::prod_beat_t   beat_o
);
  import hsvrgb_pkg::*;

  // Stage one registers.
  logic              vld1_r;
  logic [6:0]        v1_r, v1_nxt;
  logic [6:0]        s1_r, s1_nxt;
  logic [SECT_W-1:0] sect1_r, sect1_nxt;
  logic [5:0]        d1_r, d1_nxt;
  logic [8:0]        base;

  // Stage two registers.
  logic              vld2_r;
  logic [VK_W-1:0]   vk2_r, vk2_nxt;
  logic [WT_W-1:0]   wlo2_r, wlo2_nxt;
  logic [WT_W-1:0]   wadj2_r, wadj2_nxt;
  logic [SECT_W-1:0] sect2_r;

  // Stage three registers.
  prod_beat_t        beat_r;
  logic [NUM_W-1:0]  hi_nxt, lo_nxt, adj_nxt;

  // Clamp the percentages and split the hue into sector and offset.
  always_comb begin
    s1_nxt = (saturation > PCT_MAX) ? PCT_MAX : saturation;
    v1_nxt = (brightness > PCT_MAX) ? PCT_MAX : brightness;
    sect1_nxt = '0;
    for (int k = 1; k <= SECT_MAXK; k++) begin
      if (hue >= 9'(SECT_SPAN * k)) begin
        sect1_nxt = 4'(k);
      end
    end
    base   = 9'(sect1_nxt) * 9'(SECT_SPAN);
    d1_nxt = 6'(hue - base);
  end

  // Scale brightness to bytes and form the two weights.
  always_comb begin
    vk2_nxt   = 15'(v1_r) * 15'd255;
    wlo2_nxt  = 13'(PCT_MAX - s1_r) * 13'(SECT_SPAN);
    wadj2_nxt = 13'(s1_r) * 13'(d1_r);
  end

  // The three numerators over the common denominator.
  always_comb begin
    hi_nxt  = 28'(vk2_r) * 28'd6000;
    lo_nxt  = 28'(vk2_r) * 28'(wlo2_r);
    adj_nxt = 28'(vk2_r) * 28'(wadj2_r);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r       <= 1'b0;
      vld2_r       <= 1'b0;
      beat_r.valid <= 1'b0;
    end else begin
      vld1_r       <= fire;
      vld2_r       <= vld1_r;
      beat_r.valid <= vld2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    v1_r          <= v1_nxt;
    s1_r          <= s1_nxt;
    sect1_r       <= sect1_nxt;
    d1_r          <= d1_nxt;
    vk2_r         <= vk2_nxt;
    wlo2_r        <= wlo2_nxt;
    wadj2_r       <= wadj2_nxt;
    sect2_r       <= sect1_r;
    beat_r.sector <= sect2_r;
    beat_r.hi     <= hi_nxt;
    beat_r.lo     <= lo_nxt;
    beat_r.adj    <= adj_nxt;
  end

  assign beat_o = beat_r;

endmodule

`default_nettype wire

### sv/hsvrgb_mix.sv
// Channel mix stage: picks each channel's numerator from the sector.
`default_nettype none

module hsvrgb_mix (
  input  wire                      clk,
  input  wire                      rst_n,
  input  hsvrgb_pkg::prod_beat_t   beat_i,
  output hsvrgb_pkg::chan_beat_t   beat_o
);
  import hsvrgb_pkg::*;

  chan_beat_t       beat_r;
  logic [NUM_W-1:0] up, down;
  logic [NUM_W-1:0] red_nxt, green_nxt, blue_nxt;

  // Rising and falling edges of the colour wheel, then the sector cases.
  always_comb begin
    up   = beat_i.lo + beat_i.adj;
    down = beat_i.hi - beat_i.adj;
    case (beat_i.sector)
      SEC_RY: begin
        red_nxt = beat_i.hi; green_nxt = up;        blue_nxt = beat_i.lo;
      end
      SEC_YG: begin
        red_nxt = down;      green_nxt = beat_i.hi; blue_nxt = beat_i.lo;
      end
      SEC_GC: begin
        red_nxt = beat_i.lo; green_nxt = beat_i.hi; blue_nxt = up;
      end
      SEC_CB: begin
        red_nxt = beat_i.lo; green_nxt = down;      blue_nxt = beat_i.hi;
      end
      SEC_BM: begin
        red_nxt = up;        green_nxt = beat_i.lo; blue_nxt = beat_i.hi;
      end
      default: begin
        red_nxt = beat_i.hi; green_nxt = beat_i.lo; blue_nxt = down;
      end
    endcase
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_i.valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    beat_r.red   <= red_nxt;
    beat_r.green <= green_nxt;
    beat_r.blue  <= blue_nxt;
  end

  assign beat_o = beat_r;

  // The adjust term never exceeds the maximum, so the falling edge cannot wrap.
  a_adj_le_hi: assert property (@(posedge clk) disable iff (!rst_n)
    beat_i.valid |-> (beat_i.adj <= beat_i.hi))
    else $error("adjust term exceeds maximum");

endmodule

`default_nettype wire

### sv/hsvrgb_div.sv
// Two-stage division of a channel numerator by 600000, using a reciprocal multiply.
`default_nettype none

module hsvrgb_div (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               valid_i,
  input  wire  [hsvrgb_pkg::NUM_W-1:0]      num_i,
  output logic                              valid_o,
  output logic [hsvrgb_pkg::Q_W-1:0]        quot_o
);
  import hsvrgb_pkg::*;

  localparam int PROD_W = DIV_X_W + RCP_W;
  localparam int REM_W  = DIV_X_W + 1;

  logic               vld_a_r;
  logic [DIV_X_W-1:0] x_a_r;
  logic [Q_W-1:0]     qest_a_r, qest_a_nxt;
  logic [DIV_X_W-1:0] x_nxt;
  logic [PROD_W-1:0]  prod;

  logic               vld_b_r;
  logic [Q_W-1:0]     quot_b_r, quot_b_nxt;
  logic [REM_W-1:0]   back, rem;

  // Estimate from the truncated reciprocal; it is low by at most one.
  always_comb begin
    x_nxt      = num_i[NUM_W-1:DIV_SHIFT];
    prod       = PROD_W'(x_nxt) * PROD_W'(DIV_RCP);
    qest_a_nxt = prod[RCP_SHIFT +: Q_W];
  end

  // Remainder check and single correction.
  always_comb begin
    back       = REM_W'(qest_a_r) * REM_W'(DIV_ODD);
    rem        = REM_W'(x_a_r) - back;
    quot_b_nxt = (rem >= REM_W'(DIV_ODD)) ? (qest_a_r + 1'b1) : qest_a_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= valid_i;
      vld_b_r <= vld_a_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x_a_r    <= x_nxt;
    qest_a_r <= qest_a_nxt;
    quot_b_r <= quot_b_nxt;
  end

  assign valid_o = vld_b_r;
  assign quot_o  = quot_b_r;

  // The estimate must lie within one of the true quotient.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_a_r |-> (rem < REM_W'(2 * DIV_ODD)))
    else $error("reciprocal estimate off by more than one");

  // Channel results always fit in a byte.
  a_quot_byte: assert property (@(posedge clk) disable iff (!rst_n)
    vld_b_r |-> (quot_b_r[Q_W-1] == 1'b0))
    else $error("channel quotient exceeds a byte");

endmodule

`default_nettype wire

### sv/hsv_to_rgb_converter.sv
// HSV to RGB converter: a six-stage pipeline taking one pixel per clock.
// Throughput: one pixel per cycle; busy is low whenever reset is released.
// The rate is set by the pipeline registers alone: three product stages, one mix stage
// and a two-stage reciprocal divider for each channel; there is no feedback path.
// Reset (synchronous, active low) clears the valid bits; busy is high during reset.
`default_nettype none

module hsv_to_rgb_converter (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire  [8:0] in_hue,
  input  wire  [6:0] in_saturation,
  input  wire  [6:0] in_brightness,
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);
  import hsvrgb_pkg::*;

  logic           fire;
  prod_beat_t     prod_beat;
  chan_beat_t     chan_beat;
  logic [Q_W-1:0] q_red, q_green, q_blue;

  // Results cannot be held off, so the pipeline never stalls.
  assign busy = ~rst_n;
  assign fire = start & ~busy;

  hsvrgb_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .beat_o     (prod_beat)
  );

  hsvrgb_mix u_mix (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat_i (prod_beat),
    .beat_o (chan_beat)
  );

  // One divider per channel; the red one carries the strobe.
  hsvrgb_div u_div_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (chan_beat.valid),
    .num_i   (chan_beat.red),
    .valid_o (out_valid),
    .quot_o  (q_red)
  );

  hsvrgb_div u_div_green (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (chan_beat.valid),
    .num_i   (chan_beat.green),
    .valid_o (),
    .quot_o  (q_green)
  );

  hsvrgb_div u_div_blue (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (chan_beat.valid),
    .num_i   (chan_beat.blue),
    .valid_o (),
    .quot_o  (q_blue)
  );

  assign out_red   = q_red[7:0];
  assign out_green = q_green[7:0];
  assign out_blue  = q_blue[7:0];

  // Every accepted beat comes out once it has passed every pipeline register, and nothing else does.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(fire, 6))
    else $error("result strobe does not match accepted beats");

endmodule

`default_nettype wire
